// ----- rtl/tsbg_pkg.sv -----
// Package for the timed sine burst generator: constants, sequencer states, table function.
`default_nettype none

package tsbg_pkg;

  localparam int unsigned TABLE_BITS_DEF = 10;

  localparam int unsigned AMP_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned PHASE_W = 32;
  localparam int unsigned SINE_W  = 15;
  localparam int unsigned IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_AMPLITUDE    = 2'd0;
  localparam logic [IDX_W-1:0] REG_PHASE_PER_US = 2'd1;
  localparam logic [IDX_W-1:0] REG_DURATION_US  = 2'd2;

  localparam logic [AMP_W-1:0]   AMPLITUDE_RST    = 16'd819;
  localparam logic [PHASE_W-1:0] PHASE_PER_US_RST = 32'd365072220;
  localparam logic [TIME_W-1:0]  DURATION_US_RST  = 32'd170000;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PHASE,
    ST_ROM,
    ST_AMP,
    ST_OUT
  } tsbg_state_e;

  // Quarter-wave entry idx of a table with 2^tb steps, unsigned Q0.15, via Taylor series.
  function automatic logic [SINE_W-1:0] quarter_entry(input int unsigned idx,
                                                       input int unsigned tb);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] mag;
    logic [63:0] v;
    longint      sum;
    x = (64'(idx) * HALF_PI_Q30) >> tb;
    term = x;
    sum = longint'(x);
    for (int unsigned k = 1; k <= 9; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    mag = 64'(sum);
    v = (mag * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SINE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/timed_sine_burst_generator.sv -----
// Timed sine burst generator: burst timing, shared multiplier and sine table lookup.
// A live tick passes through phase multiply, table read, amplitude multiply and output load;
// a tick that ends a run goes from the phase step straight to the output load; one shared multiplier.
// Throughput: a live tick is taken only once the previous one is loaded into the output register;
// a tick without heartbeat every cycle while idle; a full output register holds the sequencer and the input.
// Reset: asynchronous, active low; configuration registers return to their defaults and a new run starts.
`default_nettype none

module timed_sine_burst_generator import tsbg_pkg::*; #(
  parameter int unsigned TableBits = TABLE_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [IDX_W-1:0]     cfg_index_i,
  input  wire logic [31:0]          cfg_data_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [31:0]          s_axis_tdata,  // now_us[31:0]
  input  wire logic                 s_axis_tuser,  // alive
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [47:0]               m_axis_tdata,  // torque[15:0], elapsed[47:16]
  output logic                      m_axis_tlast   // done_res
);

  localparam int unsigned RomDepth = (1 << TableBits) + 1;
  localparam int unsigned AddrW    = TableBits + 1;

  typedef logic [SINE_W-1:0] rom_t [RomDepth];

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned i = 0; i < RomDepth; i++) begin
      r[i] = quarter_entry(i, TableBits);
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  tsbg_state_e state_q, state_d;

  logic [AMP_W-1:0]   amplitude_q;
  logic [PHASE_W-1:0] phase_per_us_q;
  logic [TIME_W-1:0]  duration_us_q;

  logic               awaiting_q;
  logic [TIME_W-1:0]  start_q;
  logic [TIME_W-1:0]  elapsed_q;
  logic               done_q;
  logic [31:0]        mul_q;
  logic [1:0]         quad_q;
  logic [SINE_W-1:0]  rom_q;

  logic               out_valid_q;
  logic [AMP_W-1:0]   out_torque_q;
  logic [TIME_W-1:0]  out_elapsed_q;
  logic               out_done_q;

  logic               in_accept;
  logic               out_free;
  logic               mul_amp_sel;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [31:0]        mul_res;
  logic [TIME_W-1:0]  start_sel;
  logic [TableBits-1:0] tab_k;
  logic [AddrW-1:0]   rom_addr;
  logic [AMP_W-1:0]   sine_s;
  logic [31:0]        rounded;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = s_axis_tvalid && s_axis_tready;
  assign out_free    = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && s_axis_tuser) begin
          state_d = ST_PHASE;
        end
      end
      ST_PHASE: begin
        if (elapsed_q < duration_us_q) begin
          state_d = ST_ROM;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_ROM:  state_d = ST_AMP;
      ST_AMP:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    mul_amp_sel   = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_AMP:  mul_amp_sel   = 1'b1;
      default: begin
        s_axis_tready = 1'b0;
        mul_amp_sel   = 1'b0;
      end
    endcase
  end

  // Low half of the product is the same for signed and unsigned operands.
  assign sine_s  = quad_q[1] ? (AMP_W'(0) - {1'b0, rom_q}) : {1'b0, rom_q};
  assign mul_a   = mul_amp_sel ? {{(32 - AMP_W){amplitude_q[AMP_W-1]}}, amplitude_q}
                               : phase_per_us_q;
  assign mul_b   = mul_amp_sel ? {{(32 - AMP_W){sine_s[AMP_W-1]}}, sine_s} : elapsed_q;
  assign mul_res = 32'(mul_a * mul_b);

  assign start_sel = awaiting_q ? s_axis_tdata : start_q;
  assign tab_k     = mul_q[29 -: TableBits];
  assign rom_addr  = mul_q[30] ? (AddrW'(1 << TableBits) - {1'b0, tab_k}) : {1'b0, tab_k};
  assign rounded   = mul_q + 32'd16384;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      amplitude_q    <= AMPLITUDE_RST;
      phase_per_us_q <= PHASE_PER_US_RST;
      duration_us_q  <= DURATION_US_RST;
      awaiting_q     <= 1'b1;
      start_q        <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_AMPLITUDE:    amplitude_q    <= cfg_data_i[AMP_W-1:0];
          REG_PHASE_PER_US: phase_per_us_q <= cfg_data_i;
          REG_DURATION_US:  duration_us_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_IDLE && in_accept && s_axis_tuser) begin
        awaiting_q <= 1'b0;
        start_q    <= start_sel;
      end
      if (state_q == ST_PHASE && !(elapsed_q < duration_us_q)) begin
        awaiting_q <= 1'b1;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        elapsed_q <= s_axis_tdata - start_sel;
      end
      ST_PHASE: begin
        done_q <= !(elapsed_q < duration_us_q);
        mul_q  <= mul_res;
      end
      ST_ROM: begin
        rom_q  <= SineRom[rom_addr];
        quad_q <= mul_q[31:30];
      end
      ST_AMP: begin
        mul_q <= mul_res;
      end
      ST_OUT: begin
        if (out_free) begin
          out_torque_q  <= done_q ? '0 : rounded[30:15];
          out_elapsed_q <= elapsed_q;
          out_done_q    <= done_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_elapsed_q, out_torque_q};
  assign m_axis_tlast  = out_done_q;

endmodule

`default_nettype wire

// ----- dv/burst_torque_checker.sv -----
// Checker for the timed sine burst generator: tracks registers, predicts torque items, compares.
`timescale 1ns / 1ps

module burst_torque_checker import tsbg_pkg::*; #(
  parameter int unsigned TableBits = TABLE_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  input  wire logic             cfg_ready_i,
  input  wire logic [IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]      cfg_data_i,
  input  wire logic             s_tvalid_i,
  input  wire logic             s_tready_i,
  input  wire logic [31:0]      s_tdata_i,
  input  wire logic             s_tuser_i,
  input  wire logic             m_tvalid_i,
  input  wire logic             m_tready_i,
  input  wire logic [47:0]      m_tdata_i,
  input  wire logic             m_tlast_i,
  output int                    errors_o,
  output int                    pending_o,
  output int                    results_o,
  output int                    ends_o
);

  localparam int unsigned Steps = 1 << TableBits;

  typedef struct packed {
    logic signed [AMP_W-1:0] torque;
    logic [TIME_W-1:0]       elapsed;
    logic                    done;
  } torque_item_t;

  logic [SINE_W-1:0]       quarter_wave [0:Steps];
  logic signed [AMP_W-1:0] amp_reg;
  logic [PHASE_W-1:0]      ppu_reg;
  logic [TIME_W-1:0]       dur_reg;
  logic                    run_idle;
  logic [TIME_W-1:0]       run_start;
  torque_item_t            torque_due [$];
  int                      mismatches;
  int                      checked;
  int                      burst_ends;

  function automatic logic [SINE_W-1:0] wave_entry(input int unsigned i);
    logic [63:0] ang;
    logic [63:0] pw;
    logic [63:0] scaled;
    longint      acc;
    ang = (64'(i) * HALF_PI_Q30) >> TableBits;
    pw = ang;
    acc = longint'(ang);
    for (int n = 3; n <= 19; n += 2) begin
      pw = (((pw * ang) >> 30) * ang) >> 30;
      pw = pw / 64'(n * (n - 1));
      if (n % 4 == 3) begin
        acc = acc - longint'(pw);
      end else begin
        acc = acc + longint'(pw);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    scaled = (64'(acc) * 64'd32767 + 64'd536870912) >> 30;
    return (scaled > 64'd32767) ? 15'h7fff : scaled[SINE_W-1:0];
  endfunction

  function automatic int sine_at(input logic [PHASE_W-1:0] ph);
    logic [1:0]          quad;
    logic [TableBits-1:0] k;
    int                  mag;
    quad = ph[31:30];
    k = ph[29 -: TableBits];
    if (quad[0]) begin
      mag = int'(quarter_wave[Steps - int'(k)]);
    end else begin
      mag = int'(quarter_wave[k]);
    end
    return quad[1] ? -mag : mag;
  endfunction

  function automatic void predict_tick(input logic [TIME_W-1:0] now);
    torque_item_t       r;
    logic [TIME_W-1:0]  span;
    logic [PHASE_W-1:0] ph;
    longint             prod;
    if (run_idle) begin
      run_idle = 1'b0;
      run_start = now;
    end
    span = now - run_start;
    r.elapsed = span;
    r.done = 1'b0;
    r.torque = '0;
    if (span < dur_reg) begin
      ph = ppu_reg * span;
      prod = longint'(amp_reg) * longint'(sine_at(ph));
      prod = (prod + 64'sd16384) >>> 15;
      r.torque = prod[15:0];
    end else begin
      r.done = 1'b1;
      run_idle = 1'b1;
    end
    torque_due.push_back(r);
  endfunction

  initial begin
    for (int i = 0; i <= Steps; i++) begin
      quarter_wave[i] = wave_entry(i);
    end
  end

  always @(posedge clk_i) begin
    torque_item_t got;
    torque_item_t want;
    if (!rst_ni) begin
      amp_reg = AMPLITUDE_RST;
      ppu_reg = PHASE_PER_US_RST;
      dur_reg = DURATION_US_RST;
      run_idle = 1'b1;
      run_start = '0;
      torque_due.delete();
      mismatches = 0;
      checked = 0;
      burst_ends = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_AMPLITUDE:    amp_reg = cfg_data_i[AMP_W-1:0];
          REG_PHASE_PER_US: ppu_reg = cfg_data_i;
          REG_DURATION_US:  dur_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got.torque = m_tdata_i[15:0];
        got.elapsed = m_tdata_i[47:16];
        got.done = m_tlast_i;
        checked++;
        if (got.done) begin
          burst_ends++;
        end
        if (torque_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: item with none due: torque %0d elapsed %0d done %0b", $realtime,
                     $signed(got.torque), got.elapsed, got.done);
          end
        end else begin
          want = torque_due.pop_front();
          if (got.torque !== want.torque || got.elapsed !== want.elapsed ||
              got.done !== want.done) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: torque %0d/%0d elapsed %0d/%0d done %0b/%0b (expected/actual)",
                       $realtime, $signed(want.torque), $signed(got.torque), want.elapsed,
                       got.elapsed, want.done, got.done);
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i && s_tuser_i) begin
        predict_tick(s_tdata_i);
      end
    end
    errors_o  <= mismatches;
    pending_o <= torque_due.size();
    results_o <= checked;
    ends_o    <= burst_ends;
  end

endmodule

// ----- dv/timed_sine_burst_generator_tb.sv -----
// Testbench top for the timed sine burst generator: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module timed_sine_burst_generator_tb import tsbg_pkg::*;;

  localparam int IdleLimit = 2000;
  localparam int HoldCycles = 300;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [31:0]      cfg_data;
  logic             s_tvalid;
  logic             s_tready;
  logic [31:0]      s_tdata;
  logic             s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [47:0]      m_tdata;
  logic             m_tlast;

  int errors;
  int pending;
  int results;
  int ends;
  int quiet_cycles;
  int ticks_sent;
  int live_sent;
  int settings;
  int hold_requests;
  int holds_taken;
  bit no_idle;

  always #6 clk = ~clk;

  timed_sine_burst_generator dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  burst_torque_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tlast_i   (m_tlast),
    .errors_o    (errors),
    .pending_o   (pending),
    .results_o   (results),
    .ends_o      (ends)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("timed_sine_burst_generator: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic tick_send(input logic [31:0] now, input logic alive);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= now;
    s_tuser  <= alive;
    do @(posedge clk); while (!s_tready);
    ticks_sent++;
    if (alive) begin
      live_sent++;
    end
  endtask

  task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_registers(input logic [15:0] amp, input logic [31:0] ppu,
                               input logic [31:0] dur);
    drain();
    reg_write(REG_AMPLITUDE, {16'($urandom), amp});
    reg_write(REG_PHASE_PER_US, ppu);
    reg_write(REG_DURATION_US, dur);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  initial begin
    int stall;
    m_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (holds_taken != hold_requests) begin
        stall = HoldCycles;
        holds_taken++;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 15);
      end
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    logic [15:0]  amp;
    logic [31:0]  ppu;
    logic [31:0]  dur;
    logic [31:0]  clock_us;
    int unsigned  step_us;
    int           pick;
    int           live_in_phase;
    ticks_sent = 0;
    live_sent = 0;
    settings = 0;
    hold_requests = 0;
    holds_taken = 0;
    no_idle = 1'b0;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_AMPLITUDE;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default registers: ignored tick, start near wrap, elapsed across wrap, long gap ends run
    tick_send(32'd5, 1'b0);
    tick_send(32'hffff_fff0, 1'b1);
    tick_send(32'h0000_0010, 1'b1);
    tick_send(32'hffff_ffff, 1'b0);
    tick_send(32'h7fff_ffff, 1'b1);
    tick_send(32'd123, 1'b1);

    // quarter turn per microsecond walks all four quadrants at the table ends
    set_registers(16'h8000, 32'h4000_0000, 32'd4);
    for (int i = 0; i < 6; i++) begin
      tick_send(32'(i), 1'b1);
    end

    // zero duration ends the run on its start tick
    set_registers(16'h7fff, 32'hffff_ffff, 32'd0);
    tick_send(32'hffff_ffff, 1'b1);
    tick_send(32'd0, 1'b1);
    tick_send(32'd0, 1'b0);

    // longest duration, reached only by the largest elapsed
    set_registers(16'h0000, 32'h0123_4567, 32'hffff_ffff);
    tick_send(32'd0, 1'b1);
    tick_send(32'hffff_fffe, 1'b1);
    tick_send(32'hffff_ffff, 1'b1);

    for (int p = 0; p < 20; p++) begin
      case ($urandom_range(0, 3))
        0:       amp = 16'h8000;
        1:       amp = 16'h7fff;
        default: amp = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       ppu = 32'h0;
        1:       ppu = 32'hffff_ffff;
        default: ppu = $urandom;
      endcase
      step_us = $urandom_range(1, 3000);
      case ($urandom_range(0, 7))
        0:       dur = 32'h0;
        1:       dur = 32'hffff_ffff;
        default: dur = step_us * $urandom_range(0, 10) +
                       ($urandom_range(0, 1) ? 0 : $urandom_range(0, step_us - 1));
      endcase
      set_registers(amp, ppu, dur);
      no_idle = (p % 4 == 3) || (p == 5);
      if (p == 5) begin
        hold_requests++;
      end
      clock_us = ($urandom_range(0, 2) == 0) ? 32'hffff_ffff - $urandom_range(0, 20000)
                                             : $urandom;
      live_in_phase = 0;
      while (live_in_phase < 50) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          tick_send($urandom, 1'b0);
        end else begin
          if (pick < 15) begin
            tick_send($urandom, 1'b1);
          end else begin
            clock_us += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2 * step_us) : step_us;
            tick_send(clock_us, 1'b1);
          end
          live_in_phase++;
        end
      end
    end

    drain();
    $display("Sent %0d ticks, %0d with heartbeat, over %0d register settings.",
             ticks_sent, live_sent, settings + 1);
    $display("Checked %0d torque items, %0d of them closing a burst.", results, ends);
    if (errors == 0 && pending == 0) begin
      $display("timed_sine_burst_generator: match");
    end else begin
      $display("timed_sine_burst_generator: mismatch");
    end
    $finish;
  end

endmodule
